// ===== src/spf_pkg.sv =====
// ---------------------------------------------------------------------------
// spf_pkg
// Types and constants shared by the scanline polygon span fill block.
// ---------------------------------------------------------------------------
package spf_pkg;

   localparam int XW = 10;
   localparam int YW = 9;
   localparam int MAX_VERTICES_DEF = 16;
   localparam int QW = 20;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_FILL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_EDGE,
      ST_DIV,
      ST_STORE,
      ST_NEXT,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_EMIT_RD,
      ST_EMIT_RD2,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic start_fill;
      logic rd_a;
      logic rd_b;
      logic edge_setup;
      logic div_step;
      logic store_cross;
      logic next_edge;
      logic sort_rd;
      logic sort_cmp;
      logic emit_rd;
      logic emit_rd2;
      logic emit_wait;
      logic emit_load;
      logic empty_load;
   } cmd_type;

   typedef struct packed {
      logic edge_hit;
      logic div_done;
      logic edges_done;
      logic sort_done;
      logic emit_done;
      logic none;
   } status_type;

endpackage

// ===== src/spf_datapath.sv =====
// ---------------------------------------------------------------------------
// spf_datapath
// Vertex and crossing memories, edge setup, serial divider, insertion sort
// and span output register.
// ---------------------------------------------------------------------------
module spf_datapath #(
   parameter int MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic                    restart,
   input  logic [spf_pkg::XW-1:0]  vertex_x,
   input  logic [spf_pkg::YW-1:0]  vertex_y,
   input  logic [spf_pkg::YW-1:0]  row,
   input  spf_pkg::cmd_type        cmd,
   output spf_pkg::status_type     status,
   output logic                    span_valid,
   output logic [spf_pkg::XW-1:0]  span_start,
   output logic [spf_pkg::XW-1:0]  span_end,
   output logic [spf_pkg::YW-1:0]  span_row,
   output logic                    last
);
   import spf_pkg::*;

   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int PW = XW + YW + 1;

   logic [XW-1:0] vx_mem [MAX_VERTICES];
   logic [YW-1:0] vy_mem [MAX_VERTICES];
   logic [XW-1:0] cr_mem [MAX_VERTICES];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] edge_ff;
   logic [CW-1:0] k_ff;
   logic [YW-1:0] row_ff;
   logic [XW-1:0] x0_ff;
   logic [YW-1:0] y0_ff;
   logic [XW-1:0] rdx_ff;
   logic [YW-1:0] rdy_ff;

   logic [XW-1:0] xa_ff;
   logic          neg_ff;
   logic [PW-1:0] rem_ff;
   logic [PW-1:0] quo_ff;
   logic [YW-1:0] dy_ff;
   logic [4:0]    bit_ff;

   logic [CW-1:0] si_ff, sj_ff;
   logic [XW-1:0] key_ff;
   logic          key_pend_ff;
   logic          sort_shift_c;
   logic [CW-1:0] cr_rd_addr;
   logic [XW-1:0] cr_rd_ff;
   logic [CW-1:0] pair_ff;
   logic [XW-1:0] e0_ff;

   logic [CW-1:0] nxt;
   logic [CW-1:0] rd_addr;

   always_comb begin
      count_in = count_ff;
      if (load_en) begin
         if (restart) count_in = CW'(1);
         else if (count_ff < CW'(MAX_VERTICES)) count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (load_en && (restart || count_ff < CW'(MAX_VERTICES))) begin
         vx_mem[restart ? IW'(0) : count_ff[IW-1:0]] <= vertex_x;
         vy_mem[restart ? IW'(0) : count_ff[IW-1:0]] <= vertex_y;
      end
   end

   assign nxt = (edge_ff + CW'(1) < n_ff) ? edge_ff + CW'(1) : '0;
   assign rd_addr = cmd.rd_a ? edge_ff : nxt;

   always_ff @(posedge clock) begin
      if (cmd.rd_a || cmd.rd_b) begin
         rdx_ff <= vx_mem[rd_addr[IW-1:0]];
         rdy_ff <= vy_mem[rd_addr[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_fill) begin
         row_ff  <= row;
         n_ff    <= count_ff;
         edge_ff <= '0;
         k_ff    <= '0;
      end
      if (cmd.rd_b) begin
         x0_ff <= rdx_ff;
         y0_ff <= rdy_ff;
      end
      if (cmd.next_edge) edge_ff <= edge_ff + CW'(1);
      if (cmd.store_cross) k_ff <= k_ff + CW'(1);
   end

   logic [XW-1:0] xa_c, xb_c;
   logic [YW-1:0] ya_c, yb_c;
   logic          hit_c;
   always_comb begin
      if (y0_ff <= rdy_ff) begin
         xa_c = x0_ff; ya_c = y0_ff; xb_c = rdx_ff; yb_c = rdy_ff;
      end else begin
         xa_c = rdx_ff; ya_c = rdy_ff; xb_c = x0_ff; yb_c = y0_ff;
      end
      hit_c = (ya_c <= row_ff) && (row_ff < yb_c) && (k_ff < CW'(MAX_VERTICES));
   end

   logic [XW-1:0] adx_c;
   logic [YW-1:0] dr_c;
   logic [PW-1:0] num_c;
   logic          hit_ff;
   always_comb begin
      adx_c = (xb_c >= xa_c) ? xb_c - xa_c : xa_c - xb_c;
      dr_c  = row_ff - ya_c;
      num_c = PW'(adx_c) * PW'(dr_c);
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_setup) begin
         hit_ff  <= hit_c;
         xa_ff   <= xa_c;
         neg_ff  <= xb_c < xa_c;
         dy_ff   <= yb_c - ya_c;
         quo_ff  <= num_c;
         rem_ff  <= '0;
         bit_ff  <= 5'(PW);
      end else if (cmd.div_step) begin
         logic [PW:0] t;
         t = {rem_ff, quo_ff[PW-1]};
         if (t >= (PW+1)'(dy_ff)) begin
            rem_ff <= PW'(t - (PW+1)'(dy_ff));
            quo_ff <= {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_ff <= t[PW-1:0];
            quo_ff <= {quo_ff[PW-2:0], 1'b0};
         end
         bit_ff <= bit_ff - 5'd1;
      end
   end

   logic [PW-1:0] qc;
   logic [XW-1:0] cross_c;
   always_comb begin
      qc = quo_ff + PW'(neg_ff && rem_ff != '0);
      cross_c = neg_ff ? xa_ff - qc[XW-1:0] : xa_ff + qc[XW-1:0];
   end

   // Insertion sort: sj_ff walks down, key_ff holds the value being placed.
   // The next key is read in the cycle that writes the current one back.
   assign sort_shift_c = (sj_ff != '0) && (cr_rd_ff > key_ff);

   always_comb begin
      if (cmd.emit_rd) cr_rd_addr = {pair_ff[CW-2:0], 1'b0};
      else if (cmd.emit_rd2 || cmd.emit_wait) cr_rd_addr = {pair_ff[CW-2:0], 1'b1};
      else if (cmd.sort_rd) cr_rd_addr = sj_ff - CW'(1);
      else if (cmd.sort_cmp && !sort_shift_c) cr_rd_addr = si_ff + CW'(1);
      else cr_rd_addr = si_ff;
   end

   always_ff @(posedge clock) begin
      cr_rd_ff <= cr_mem[cr_rd_addr[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.store_cross) cr_mem[k_ff[IW-1:0]] <= cross_c;
      else if (cmd.sort_cmp) begin
         if (sort_shift_c) cr_mem[sj_ff[IW-1:0]] <= cr_rd_ff;
         else cr_mem[sj_ff[IW-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_fill) begin
         si_ff <= CW'(1);
         sj_ff <= CW'(1);
         key_pend_ff <= 1'b1;
         pair_ff <= '0;
      end
      if (cmd.sort_rd && key_pend_ff) begin
         key_ff <= cr_rd_ff;
         key_pend_ff <= 1'b0;
      end
      if (cmd.sort_cmp) begin
         if (sort_shift_c) sj_ff <= sj_ff - CW'(1);
         else begin
            si_ff <= si_ff + CW'(1);
            sj_ff <= si_ff + CW'(1);
            key_pend_ff <= 1'b1;
         end
      end
      if (cmd.emit_rd2) e0_ff <= cr_rd_ff;
      if (cmd.emit_load) pair_ff <= pair_ff + CW'(1);
   end

   logic [CW:0] two_p;
   assign two_p = {pair_ff, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         span_valid <= 1'b0;
      end else if (cmd.emit_load) begin
         span_valid <= 1'b1;
         span_start <= e0_ff;
         span_end   <= ((CW+1)'(two_p) < (CW+1)'(k_ff)) ? cr_rd_ff : e0_ff;
         span_row   <= row_ff;
         last       <= ((CW+1)'(two_p) + (CW+1)'(1) >= (CW+1)'(k_ff));
      end else if (cmd.empty_load) begin
         span_valid <= 1'b0;
         span_start <= '0;
         span_end   <= '0;
         span_row   <= row_ff;
         last       <= 1'b1;
      end
   end

   assign status.edge_hit   = hit_ff;
   assign status.div_done   = (bit_ff == 5'd0);
   assign status.edges_done = (edge_ff >= n_ff);
   assign status.sort_done  = (si_ff >= k_ff);
   assign status.emit_done  = ({pair_ff, 1'b0} + (CW+1)'(2) >= (CW+1)'(k_ff));
   assign status.none       = (k_ff == '0);
endmodule

// ===== src/spf_control.sv =====
// ---------------------------------------------------------------------------
// spf_control
// Sequencer for one fill command: edge walk, division, sort and span output.
// ---------------------------------------------------------------------------
module spf_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                fill_go,
   input  spf_pkg::status_type status,
   input  logic                rsp_stall,
   output spf_pkg::cmd_type    cmd,
   output logic                busy
);
   import spf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (fill_go) state_in = ST_NEXT;
         ST_NEXT:     state_in = status.edges_done ? ST_SORT_RD : ST_RD_A;
         ST_RD_A:     state_in = ST_RD_B;
         ST_RD_B:     state_in = ST_EDGE;
         ST_EDGE:     state_in = ST_DIV;
         ST_DIV:      if (!status.edge_hit) state_in = ST_STORE;
                      else if (status.div_done) state_in = ST_STORE;
         ST_STORE:    state_in = ST_NEXT;
         ST_SORT_RD:  if (status.none) state_in = ST_EMPTY;
                      else if (status.sort_done) state_in = ST_EMIT_RD;
                      else state_in = ST_SORT_CMP;
         ST_SORT_CMP: state_in = ST_SORT_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_RD2;
         ST_EMIT_RD2: state_in = ST_EMIT;
         ST_EMIT:     if (!rsp_stall) state_in = status.emit_done ? ST_IDLE : ST_EMIT_RD;
         ST_EMPTY:    if (!rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:     cmd.start_fill = fill_go;
         ST_RD_A:     cmd.rd_a = 1'b1;
         ST_RD_B:     cmd.rd_b = 1'b1;
         ST_EDGE:     cmd.edge_setup = 1'b1;
         ST_DIV:      cmd.div_step = status.edge_hit && !status.div_done;
         ST_STORE:    begin
            cmd.store_cross = status.edge_hit;
            cmd.next_edge = 1'b1;
         end
         ST_SORT_RD:  cmd.sort_rd = 1'b1;
         ST_SORT_CMP: cmd.sort_cmp = 1'b1;
         ST_EMIT_RD:  cmd.emit_rd = 1'b1;
         ST_EMIT_RD2: cmd.emit_rd2 = 1'b1;
         ST_EMIT:     begin
            cmd.emit_wait = 1'b1;
            cmd.emit_load = !rsp_stall;
         end
         ST_EMPTY:    cmd.empty_load = !rsp_stall;
         default:     cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ===== src/scanline_polygon_span_fill.sv =====
// ---------------------------------------------------------------------------
// scanline_polygon_span_fill
// Loads polygon vertices and emits the filled spans of one scanline row.
//
//   channel  direction  handshake
//   req_     in         req_valid / req_stall
//   rsp_     out        rsp_valid / rsp_stall
//
// A fill walks each edge in turn and runs the 20-step bit-serial divider for
// each edge that crosses the row, then insertion-sorts the crossings and
// emits one span per pair of crossings. Reset empties the vertex store.
// A stalled result holds the sequencer; no request is taken until the last
// result of a row transfers.
// ---------------------------------------------------------------------------
module scanline_polygon_span_fill #(
   parameter int MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic                   req_restart,
   input  logic [spf_pkg::XW-1:0] req_vertex_x,
   input  logic [spf_pkg::YW-1:0] req_vertex_y,
   input  logic [spf_pkg::YW-1:0] req_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_span_valid,
   output logic [spf_pkg::XW-1:0] rsp_span_start,
   output logic [spf_pkg::XW-1:0] rsp_span_end,
   output logic [spf_pkg::YW-1:0] rsp_span_row,
   output logic                   rsp_last
);
   import spf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy, acc;
   logic       out_ff, out_in;

   assign req_stall = busy || out_ff;
   assign acc = req_valid && !req_stall;

   spf_control u_ctl (
      .clock(clock), .reset(reset), .fill_go(acc && req_cmd == CMD_FILL),
      .status(status), .rsp_stall(rsp_stall || out_ff), .cmd(cmd), .busy(busy)
   );

   spf_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock(clock), .reset(reset), .load_en(acc && req_cmd == CMD_LOAD),
      .restart(req_restart), .vertex_x(req_vertex_x), .vertex_y(req_vertex_y),
      .row(req_row), .cmd(cmd), .status(status),
      .span_valid(rsp_span_valid), .span_start(rsp_span_start),
      .span_end(rsp_span_end), .span_row(rsp_span_row), .last(rsp_last)
   );

   always_comb begin
      out_in = out_ff;
      if (cmd.emit_load || cmd.empty_load) out_in = 1'b1;
      else if (out_ff && !rsp_stall) out_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff <= 1'b0;
      else out_ff <= out_in;
   end

   assign rsp_valid = out_ff;
endmodule
